### design/apt_pkg.sv
// Shared types and constants for the arc polyline tessellator.
// Holds the sequencer states, the CORDIC handshake structs and the angle table.
// No dependencies.
`default_nettype none
package apt_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VEC0,
        S_VEC1,
        S_SWEEP,
        S_MUL,
        S_RND,
        S_DIV,
        S_ROT,
        S_ROTWAIT,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_req;

    typedef struct packed {
        logic done;
    } t_cordic_rsp;

    // Edge opcodes.
    localparam logic OP_LINE = 1'b0;
    localparam logic OP_ARC  = 1'b1;

    // Inverse CORDIC gain, 32 fraction bits.
    localparam logic [31:0] KINV = 32'd2608131496;
    localparam int GUARD_BITS = 8;
    localparam int TABLE_LEN = 24;

    // atan(2^-i) in 32-bit fractions of a turn, rounded.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/apt_cordic.sv
// Iterative CORDIC unit, one micro-rotation per clock, vectoring or rotation.
// Depends on apt_pkg for the angle table and the request/response structs.
`default_nettype none
module apt_cordic #(
    parameter int DW    = 36,
    parameter int STEPS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  apt_pkg::t_cordic_req    i_req,
    input  wire  signed [DW-1:0]    i_x,
    input  wire  signed [DW-1:0]    i_y,
    input  wire         [31:0]      i_z,
    output apt_pkg::t_cordic_rsp    o_rsp,
    output logic signed [DW-1:0]    o_x,
    output logic signed [DW-1:0]    o_y,
    output logic        [31:0]      o_z
);

    localparam int NSTEP = (STEPS < apt_pkg::TABLE_LEN) ? STEPS : apt_pkg::TABLE_LEN;
    localparam int IW    = $clog2(NSTEP + 1);

    logic signed [DW-1:0] r_x, n_x, r_y, n_y;
    logic signed [33:0]   r_z, n_z;
    logic [IW-1:0]        r_i, n_i;
    logic                 r_busy, n_busy, r_done, n_done, r_vec, n_vec;

    logic signed [DW-1:0] w_xs, w_ys;
    logic signed [33:0]   w_atan, w_zs;
    logic                 w_ccw;

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = $signed({2'b00, apt_pkg::atan_turn(5'(r_i))});
    // Counter-clockwise micro-rotation drives y up in vectoring and z down in rotation.
    assign w_ccw  = r_vec ? r_y[DW-1] : ~r_z[33];
    assign w_zs   = $signed({{2{i_z[31]}}, i_z});

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_i    = r_i;
        n_busy = r_busy;
        n_vec  = r_vec;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_i    = '0;
            n_vec  = i_req.vectoring;
            n_y    = i_y;
            n_x    = i_x;
            if (i_req.vectoring) begin
                n_z = 34'sd0;
                if (i_x[DW-1]) begin
                    n_x = -i_x;
                    n_y = -i_y;
                    n_z = 34'sh0_8000_0000;
                end
            end else begin
                n_z = w_zs;
                if (w_zs > 34'sd1073741824) begin
                    n_z = w_zs - 34'sd2147483648;
                    n_x = -i_x;
                end else if (w_zs < -34'sd1073741824) begin
                    n_z = w_zs + 34'sd2147483648;
                    n_x = -i_x;
                end
            end
        end else if (r_busy) begin
            if (w_ccw) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_atan;
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_atan;
            end
            n_i = r_i + 1'b1;
            if (r_i == IW'(NSTEP - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_i   <= n_i;
        r_vec <= n_vec;
    end

    assign o_rsp.done = r_done;
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_z        = r_z[31:0];

endmodule
`default_nettype wire

### design/arc_polyline_tessellator_core.sv
// Top level of the arc polyline tessellator: input capture, sequencer,
// serial multiplier and divider, duplicate filter and output register.
// Depends on apt_pkg and apt_cordic.
//
// Each input transfer is one polyline edge; the block drops s_tready until all
// points of that edge have been handed to the output register. An arc edge
// runs two vectorings on the single shared CORDIC unit (one when the end point
// sits on the center), then bit-serial gain correction, a division for the
// segment step and one CORDIC rotation per point. Output backpressure stalls
// the emission of points. Points are delayed by one so that the final
// emitted point can carry tlast.
`default_nettype none
module arc_polyline_tessellator_core #(
    parameter int COORD_WIDTH  = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_s_tvalid,
    output logic                                      o_s_tready,
    // center_x, center_y, start_x, start_y, end_x, end_y, zero fill
    input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    // opcode, new_polyline, full_circle
    input  wire  [2:0]                                i_s_tuser,
    output logic                                      o_m_tvalid,
    input  wire                                       i_m_tready,
    // point_x, point_y, zero fill
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]         o_m_tdata,
    output logic                                      o_m_tlast
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 12;
    localparam int PW  = DW + 32;
    localparam int OWD = ((2*CW+7)/8)*8;
    localparam int SH1 = 32 + apt_pkg::GUARD_BITS;
    localparam int SH2 = 32 - apt_pkg::GUARD_BITS;
    localparam logic signed [DW-1:0] C_MAX = DW'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [DW-1:0] C_MIN = -C_MAX - DW'(1);

    apt_pkg::t_state r_state, n_state;

    logic signed [CW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [CW-1:0] r_ex, n_ex, r_ey, n_ey;
    logic signed [CW-1:0] r_cand_x, n_cand_x, r_cand_y, n_cand_y;
    logic signed [CW-1:0] r_pend_x, n_pend_x, r_pend_y, n_pend_y;
    logic signed [CW-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [CW-1:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic r_line, n_line, r_single, n_single, r_full, n_full, r_pass, n_pass;
    logic r_pend_v, n_pend_v, r_prev_v, n_prev_v, r_out_v, n_out_v, r_out_last, n_out_last;
    logic [15:0]   r_a0, n_a0;
    logic [16:0]   r_a1, n_a1, r_sweep, n_sweep, r_q, n_q, r_off, n_off;
    logic [DW-1:0] r_mulin, n_mulin, r_x0, n_x0;
    logic [PW-1:0] r_acc, n_acc;
    logic [4:0]    r_cnt, n_cnt;
    logic [5:0]    r_segs, n_segs, r_rem, n_rem, r_k, n_k;
    logic [6:0]    r_t, n_t;

    apt_pkg::t_cordic_req c_req;
    apt_pkg::t_cordic_rsp c_rsp;
    logic signed [DW-1:0] c_x, c_y, c_ox, c_oy;
    logic        [31:0]   c_z, c_oz;

    logic signed [CW-1:0] w_icx, w_icy, w_isx, w_isy;
    logic                 w_accept, w_slot, w_dup;
    logic [31:0]          w_zr;
    logic [16:0]          w_a0e, w_a1adj, w_sw;
    logic [17:0]          w_sg;
    logic [PW-1:0]        w_rnd;
    logic [6:0]           w_rem2, w_d2;
    logic [7:0]           w_tsum;
    logic signed [DW-1:0] w_ox, w_oy, w_px, w_py;

    assign w_icx = i_s_tdata[0*CW +: CW];
    assign w_icy = i_s_tdata[1*CW +: CW];
    assign w_isx = i_s_tdata[2*CW +: CW];
    assign w_isy = i_s_tdata[3*CW +: CW];

    assign o_s_tready = (r_state == apt_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_slot     = !r_out_v || i_m_tready;
    assign w_dup      = r_prev_v && (r_cand_x == r_prev_x) && (r_cand_y == r_prev_y);

    assign w_zr    = c_oz + 32'h0000_8000;
    assign w_a0e   = {1'b0, r_a0};
    assign w_a1adj = (r_a1 <= w_a0e) ? (r_a1 + 17'h10000) : r_a1;
    assign w_sw    = r_full ? 17'h10000 : (w_a1adj - w_a0e);
    assign w_sg    = (18'(w_sw) + 18'd2047) >> 11;
    assign w_rnd   = r_acc + (PW'(1) << ((r_pass ? SH2 : SH1) - 1));
    assign w_rem2  = {r_rem, r_sweep[5'd16 - r_cnt]};
    assign w_d2    = {r_segs, 1'b0};
    assign w_tsum  = {1'b0, r_t} + {1'b0, r_rem, 1'b0};

    // Rotated offset rounded off its 8 fraction bits to an integer, then moved to the center.
    assign w_ox = (c_ox + DW'(128)) >>> apt_pkg::GUARD_BITS;
    assign w_oy = (c_oy + DW'(128)) >>> apt_pkg::GUARD_BITS;
    assign w_px = DW'(r_cx) + w_ox;
    assign w_py = DW'(r_cy) + w_oy;

    always_comb begin
        n_state = r_state;
        n_cx = r_cx; n_cy = r_cy; n_ex = r_ex; n_ey = r_ey;
        n_cand_x = r_cand_x; n_cand_y = r_cand_y;
        n_pend_x = r_pend_x; n_pend_y = r_pend_y; n_pend_v = r_pend_v;
        n_prev_x = r_prev_x; n_prev_y = r_prev_y; n_prev_v = r_prev_v;
        n_out_x = r_out_x; n_out_y = r_out_y; n_out_last = r_out_last;
        n_out_v = r_out_v && !i_m_tready;
        n_line = r_line; n_single = r_single; n_full = r_full; n_pass = r_pass;
        n_a0 = r_a0; n_a1 = r_a1; n_sweep = r_sweep; n_q = r_q; n_off = r_off;
        n_mulin = r_mulin; n_x0 = r_x0; n_acc = r_acc; n_cnt = r_cnt;
        n_segs = r_segs; n_rem = r_rem; n_k = r_k; n_t = r_t;
        c_req.start     = 1'b0;
        c_req.vectoring = 1'b1;
        c_x = (DW'(r_ex) - DW'(r_cx)) <<< apt_pkg::GUARD_BITS;
        c_y = (DW'(r_ey) - DW'(r_cy)) <<< apt_pkg::GUARD_BITS;
        c_z = {r_a0 + r_off[15:0], 16'h0000};

        case (r_state)
            apt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cx = w_icx; n_cy = w_icy;
                    n_ex = i_s_tdata[4*CW +: CW];
                    n_ey = i_s_tdata[5*CW +: CW];
                    n_full   = i_s_tuser[2];
                    n_line   = (i_s_tuser[0] == apt_pkg::OP_LINE);
                    n_single = (w_isx == w_icx) && (w_isy == w_icy);
                    n_k      = '0;
                    n_cand_x = w_isx;
                    n_cand_y = w_isy;
                    if (i_s_tuser[1]) begin
                        n_prev_v = 1'b0;
                    end
                    if ((i_s_tuser[0] == apt_pkg::OP_LINE) ||
                        ((w_isx == w_icx) && (w_isy == w_icy))) begin
                        n_state = apt_pkg::S_EMIT;
                    end else begin
                        c_req.start = 1'b1;
                        c_x = (DW'(w_isx) - DW'(w_icx)) <<< apt_pkg::GUARD_BITS;
                        c_y = (DW'(w_isy) - DW'(w_icy)) <<< apt_pkg::GUARD_BITS;
                        n_state = apt_pkg::S_VEC0;
                    end
                end
            end
            apt_pkg::S_VEC0: begin
                if (c_rsp.done) begin
                    n_a0    = w_zr[31:16];
                    n_mulin = c_ox;
                    if ((r_ex == r_cx) && (r_ey == r_cy)) begin
                        // End point on the center: end angle is zero.
                        n_a1    = '0;
                        n_state = apt_pkg::S_SWEEP;
                    end else begin
                        c_req.start = 1'b1;
                        n_state     = apt_pkg::S_VEC1;
                    end
                end
            end
            apt_pkg::S_VEC1: begin
                if (c_rsp.done) begin
                    n_a1    = {1'b0, w_zr[31:16]};
                    n_state = apt_pkg::S_SWEEP;
                end
            end
            apt_pkg::S_SWEEP: begin
                n_sweep = w_sw;
                n_segs  = (w_sg < 18'd4) ? 6'd4 : 6'(w_sg);
                n_acc   = '0;
                n_cnt   = '0;
                n_pass  = 1'b0;
                n_state = apt_pkg::S_MUL;
            end
            apt_pkg::S_MUL: begin
                // Shift-and-add over the gain constant, most significant bit first.
                n_acc = (r_acc << 1) + (apt_pkg::KINV[5'd31 - r_cnt] ? PW'(r_mulin) : PW'(0));
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = apt_pkg::S_RND;
                end
            end
            apt_pkg::S_RND: begin
                n_cnt = '0;
                if (!r_pass) begin
                    n_mulin = DW'(w_rnd >> SH1);
                    n_acc   = '0;
                    n_pass  = 1'b1;
                    n_state = apt_pkg::S_MUL;
                end else begin
                    n_x0    = DW'(w_rnd >> SH2);
                    n_rem   = '0;
                    n_q     = '0;
                    n_state = apt_pkg::S_DIV;
                end
            end
            apt_pkg::S_DIV: begin
                // Restoring division of the sweep by the segment count.
                if (w_rem2 >= {1'b0, r_segs}) begin
                    n_rem = 6'(w_rem2 - {1'b0, r_segs});
                    n_q   = {r_q[15:0], 1'b1};
                end else begin
                    n_rem = 6'(w_rem2);
                    n_q   = {r_q[15:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    n_off   = '0;
                    n_t     = {1'b0, r_segs};
                    n_state = apt_pkg::S_ROT;
                end
            end
            apt_pkg::S_ROT: begin
                c_req.start     = 1'b1;
                c_req.vectoring = 1'b0;
                c_x     = r_x0;
                c_y     = '0;
                n_state = apt_pkg::S_ROTWAIT;
            end
            apt_pkg::S_ROTWAIT: begin
                if (c_rsp.done) begin
                    n_cand_x = (w_px > C_MAX) ? CW'(C_MAX) :
                               ((w_px < C_MIN) ? CW'(C_MIN) : CW'(w_px));
                    n_cand_y = (w_py > C_MAX) ? CW'(C_MAX) :
                               ((w_py < C_MIN) ? CW'(C_MIN) : CW'(w_py));
                    // Step the angle offset by sweep/segs with exact rounding carry.
                    if (w_tsum >= {1'b0, w_d2}) begin
                        n_t   = 7'(w_tsum - {1'b0, w_d2});
                        n_off = r_off + r_q + 17'd1;
                    end else begin
                        n_t   = 7'(w_tsum);
                        n_off = r_off + r_q;
                    end
                    n_state = apt_pkg::S_EMIT;
                end
            end
            apt_pkg::S_EMIT: begin
                if (w_dup || !r_pend_v || w_slot) begin
                    if (!w_dup) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_x    = r_pend_x;
                            n_out_y    = r_pend_y;
                            n_out_last = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend_x = r_cand_x;
                        n_pend_y = r_cand_y;
                        n_prev_v = 1'b1;
                        n_prev_x = r_cand_x;
                        n_prev_y = r_cand_y;
                    end
                    if (r_line && (r_k == 6'd0)) begin
                        n_cand_x = r_ex;
                        n_cand_y = r_ey;
                        n_k      = 6'd1;
                    end else if (!r_line && !r_single && (r_k < r_segs)) begin
                        n_k     = r_k + 6'd1;
                        n_state = apt_pkg::S_ROT;
                    end else begin
                        n_state = apt_pkg::S_FLUSH;
                    end
                end
            end
            apt_pkg::S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = apt_pkg::S_IDLE;
                end else if (w_slot) begin
                    n_out_v    = 1'b1;
                    n_out_x    = r_pend_x;
                    n_out_y    = r_pend_y;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = apt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = apt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= apt_pkg::S_IDLE;
            r_pend_v <= 1'b0;
            r_prev_v <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_prev_v <= n_prev_v;
            r_prev_x <= n_prev_x;
            r_prev_y <= n_prev_y;
            r_out_v  <= n_out_v;
        end
        r_cx <= n_cx; r_cy <= n_cy; r_ex <= n_ex; r_ey <= n_ey;
        r_cand_x <= n_cand_x; r_cand_y <= n_cand_y;
        r_pend_x <= n_pend_x; r_pend_y <= n_pend_y;
        r_out_x <= n_out_x; r_out_y <= n_out_y; r_out_last <= n_out_last;
        r_line <= n_line; r_single <= n_single; r_full <= n_full; r_pass <= n_pass;
        r_a0 <= n_a0; r_a1 <= n_a1; r_sweep <= n_sweep; r_q <= n_q; r_off <= n_off;
        r_mulin <= n_mulin; r_x0 <= n_x0; r_acc <= n_acc; r_cnt <= n_cnt;
        r_segs <= n_segs; r_rem <= n_rem; r_k <= n_k; r_t <= n_t;
    end

    apt_cordic #(
        .DW    (DW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_z     (c_z),
        .o_rsp   (c_rsp),
        .o_x     (c_ox),
        .o_y     (c_oy),
        .o_z     (c_oz)
    );

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OWD'({r_out_y, r_out_x});
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

### verif/arc_polyline_tessellator_core_tb.sv
// Self-checking testbench for arc_polyline_tessellator_core.
// Drives polyline edges over the input stream and compares emitted points with
// a fixed-point predictor of the tessellator. Depends on apt_pkg and the RTL.
`timescale 1ns / 1ps
module arc_polyline_tessellator_core_tb;

    localparam int CW = 24;
    localparam int CSTEPS = 16;
    localparam int GB = 8;
    localparam int N_RANDOM = 240;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic            opcode;
        logic            new_poly;
        logic            full;
        logic [CW-1:0]   cx;
        logic [CW-1:0]   cy;
        logic [CW-1:0]   sx;
        logic [CW-1:0]   sy;
        logic [CW-1:0]   ex;
        logic [CW-1:0]   ey;
    } t_edge;

    typedef struct packed {
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic          last;
    } t_point;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    // center_x, center_y, start_x, start_y, end_x, end_y
    logic [6*CW-1:0]  i_s_tdata = '0;
    // opcode, new_polyline, full_circle
    logic [2:0]       i_s_tuser = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    // point_x, point_y
    logic [2*CW-1:0]  o_m_tdata;
    logic             o_m_tlast;

    arc_polyline_tessellator_core #(.COORD_WIDTH(CW), .CORDIC_STEPS(CSTEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_point expected_points[$];
    int     mismatches = 0;
    longint cycles = 0;
    logic   stim_done = 1'b0;

    // Predictor copy of the duplicate-filter history.
    longint hist_x, hist_y;
    bit     hist_valid;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW-1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // round(a*b / 2^sh) with a wide intermediate
    function automatic longint unsigned mulr(longint unsigned a, logic [31:0] b, int sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << (sh-1));
        return 64'(p >> sh);
    endfunction

    function automatic logic [31:0] vector_angle(longint dx, longint dy, output longint mag);
        longint x, y, xs, ys;
        logic [31:0] z;
        x = dx <<< GB;
        y = dy <<< GB;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < CSTEPS && i < apt_pkg::TABLE_LEN; i++) begin
            xs = fshift(x, i); ys = fshift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += apt_pkg::atan_turn(5'(i));
            end else begin
                x -= ys; y += xs; z -= apt_pkg::atan_turn(5'(i));
            end
        end
        mag = x;
        return z;
    endfunction

    task automatic rotate(longint x0, logic [31:0] z, output longint ox, output longint oy);
        longint zs, x, y, xs, ys;
        zs = longint'(z) - (z[31] ? 64'sd4294967296 : 64'sd0);
        x = x0; y = 0;
        if (zs > 64'sd1073741824) begin
            zs -= 64'sd2147483648; x = -x;
        end else if (zs < -64'sd1073741824) begin
            zs += 64'sd2147483648; x = -x;
        end
        for (int i = 0; i < CSTEPS && i < apt_pkg::TABLE_LEN; i++) begin
            xs = fshift(x, i); ys = fshift(y, i);
            if (zs >= 0) begin
                x -= ys; y += xs; zs -= longint'(apt_pkg::atan_turn(5'(i)));
            end else begin
                x += ys; y -= xs; zs += longint'(apt_pkg::atan_turn(5'(i)));
            end
        end
        ox = fshift(x + (1 <<< (GB-1)), GB);
        oy = fshift(y + (1 <<< (GB-1)), GB);
    endtask

    task automatic push_point(longint px, longint py, ref int n);
        t_point p;
        px = sat(px); py = sat(py);
        if (hist_valid && px == hist_x && py == hist_y) return;
        hist_x = px; hist_y = py; hist_valid = 1;
        p.px = px[CW-1:0]; p.py = py[CW-1:0]; p.last = 1'b0;
        expected_points = {expected_points, p};
        n++;
    endtask

    task automatic predict_edge(t_edge e);
        longint cx, cy, sx, sy, ex, ey, mag, dmag, x0, ox, oy;
        longint unsigned r, off;
        logic [31:0] z0, a0, a1, sweep, segs, ang;
        int n;
        n = 0;
        cx = longint'(signed'(e.cx)); cy = longint'(signed'(e.cy));
        sx = longint'(signed'(e.sx)); sy = longint'(signed'(e.sy));
        ex = longint'(signed'(e.ex)); ey = longint'(signed'(e.ey));
        if (e.new_poly) hist_valid = 0;
        if (e.opcode == apt_pkg::OP_LINE) begin
            push_point(sx, sy, n);
            push_point(ex, ey, n);
        end else if (sx == cx && sy == cy) begin
            push_point(sx, sy, n);
        end else begin
            z0 = vector_angle(sx - cx, sy - cy, mag);
            a0 = ((z0 + 32'h8000) >> 16) & 32'hFFFF;
            if (ex == cx && ey == cy) a1 = 0;
            else a1 = ((vector_angle(ex - cx, ey - cy, dmag) + 32'h8000) >> 16) & 32'hFFFF;
            r = mulr(longint'(mag), apt_pkg::KINV, 32 + GB);
            x0 = longint'(mulr(r, apt_pkg::KINV, 32 - GB));
            if (e.full) sweep = 65536;
            else begin
                if (a1 <= a0) a1 += 65536;
                sweep = a1 - a0;
            end
            segs = (sweep + 2047) >> 11;
            if (segs < 4) segs = 4;
            for (int k = 0; k <= segs; k++) begin
                off = (longint'(sweep) * k * 2 + segs) / (2 * longint'(segs));
                ang = (a0 + 32'(off)) & 32'hFFFF;
                rotate(x0, ang << 16, ox, oy);
                push_point(cx + ox, cy + oy, n);
            end
        end
        if (n > 0) expected_points[$].last = 1'b1;
    endtask

    task automatic send_edge(t_edge e);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {e.ey, e.ex, e.sy, e.sx, e.cy, e.cx};
        i_s_tuser <= {e.full, e.new_poly, e.opcode};
        predict_edge(e);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic t_edge make_edge(logic op, logic np, logic fc,
                                        int cx, int cy, int sx, int sy, int ex, int ey);
        t_edge e;
        e.opcode = op; e.new_poly = np; e.full = fc;
        e.cx = cx[CW-1:0]; e.cy = cy[CW-1:0]; e.sx = sx[CW-1:0];
        e.sy = sy[CW-1:0]; e.ex = ex[CW-1:0]; e.ey = ey[CW-1:0];
        return e;
    endfunction

    function automatic int rcoord(int span);
        return $urandom_range(2*span) - span;
    endfunction

    function automatic t_edge random_edge();
        t_edge e;
        int cx, cy, rad, span;
        logic [159:0] raw;
        case ($urandom_range(9))
            0: begin
                // raw noise over all bits
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                e = raw[$bits(t_edge)-1:0];
            end
            1, 2: begin
                span = $urandom_range(1) ? 4096 : 8388607;
                e = make_edge(apt_pkg::OP_LINE, 1'($urandom), 1'($urandom),
                              rcoord(span), rcoord(span), rcoord(span), rcoord(span),
                              rcoord(span), rcoord(span));
            end
            default: begin
                rad = $urandom_range(1) ? $urandom_range(1, 4000) : $urandom_range(1, 3000000);
                cx = rcoord(8388607 - 2*rad); cy = rcoord(8388607 - 2*rad);
                e = make_edge(apt_pkg::OP_ARC, 1'($urandom), ($urandom_range(3) == 0), cx, cy,
                              cx + rcoord(rad), cy + rcoord(rad),
                              cx + rcoord(rad), cy + rcoord(rad));
                if ($urandom_range(15) == 0) e.sx = e.cx;
                if ($urandom_range(15) == 0) {e.ex, e.ey} = {e.cx, e.cy};
                // near the range edge the arc saturates
                if ($urandom_range(15) == 0) e.cx = 24'h7FFF00;
            end
        endcase
        return e;
    endfunction

    t_edge directed_edges[$];

    initial begin
        hist_x = 0; hist_y = 0; hist_valid = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_edges = '{
            make_edge(apt_pkg::OP_LINE, 1'b1, 1'b0, 0, 0, 0, 0, 256, 256),
            make_edge(apt_pkg::OP_LINE, 1'b0, 1'b0, 0, 0, 256, 256, 256, 256),
            make_edge(apt_pkg::OP_LINE, 1'b0, 1'b1, 0, 0, -8388608, -8388608,
                      8388607, 8388607),
            make_edge(apt_pkg::OP_LINE, 1'b1, 1'b0, 0, 0, 8388607, 8388607,
                      -8388608, 8388607),
            make_edge(apt_pkg::OP_ARC, 1'b0, 1'b0, 100, 100, 100, 100, 0, 0),
            make_edge(apt_pkg::OP_ARC, 1'b0, 1'b1, 100, 100, 100, 100, 0, 0),
            make_edge(apt_pkg::OP_ARC, 1'b1, 1'b1, 0, 0, 2560, 0, 0, 0),
            make_edge(apt_pkg::OP_ARC, 1'b0, 1'b0, 0, 0, 2560, 0, 0, 2560),
            make_edge(apt_pkg::OP_ARC, 1'b0, 1'b0, 0, 0, 0, 2560, 0, 2560),
            make_edge(apt_pkg::OP_ARC, 1'b1, 1'b0, 500, -500, 1000, -500, 500, -500),
            make_edge(apt_pkg::OP_ARC, 1'b1, 1'b1, 8388000, 8388000, 8388600, 8388000,
                      0, 0),
            make_edge(apt_pkg::OP_ARC, 1'b0, 1'b1, -8388000, -8388000, -8388600,
                      -8388000, 0, 0),
            make_edge(apt_pkg::OP_ARC, 1'b1, 1'b0, 0, 0, 1, 0, -1, 0),
            make_edge(apt_pkg::OP_ARC, 1'b1, 1'b1, 0, 0, 1, 1, 0, 0),
            make_edge(apt_pkg::OP_ARC, 1'b0, 1'b0, -3000, 2000, -3000, 6000, -7000, 2000),
            make_edge(apt_pkg::OP_ARC, 1'b1, 1'b0, 0, 0, 4000000, -4000000,
                      4000000, 4000000),
            make_edge(apt_pkg::OP_LINE, 1'b0, 1'b0, 0, 0, 1, 1, 1, 1)
        };
        foreach (directed_edges[i]) send_edge(directed_edges[i]);
        for (int i = 0; i < N_RANDOM; ) begin
            int burst, gap;
            burst = $urandom_range(1, 6);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 20);
            for (int b = 0; b < burst && i < N_RANDOM; b++, i++) send_edge(random_edge());
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall pattern: alternates free-running and stalling stretches.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 512;
        if (stall_phase < 200) i_m_tready <= 1'b1;
        else i_m_tready <= ($urandom_range(3) != 0) && ($urandom_range(40) != 0 || 1'b1);
    end

    always @(posedge i_clk) begin
        t_point want;
        logic [CW-1:0] got_x, got_y;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_x = o_m_tdata[CW-1:0];
            got_y = o_m_tdata[2*CW-1:CW];
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d last=%0b",
                             signed'(got_x), signed'(got_y), o_m_tlast);
            end else begin
                want = expected_points.pop_front();
                if (want.px !== got_x || want.py !== got_y || want.last !== o_m_tlast) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"point mismatch: exp x=%0d y=%0d last=%0b",
                                  " got x=%0d y=%0d last=%0b"},
                                 signed'(want.px), signed'(want.py), want.last,
                                 signed'(got_x), signed'(got_y), o_m_tlast);
                end
            end
        end
    end

    initial begin
        wait (stim_done && expected_points.size() == 0);
        repeat (800) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
